// ===== design/ngsg_pkg.sv =====
`default_nettype none

package ngsg_pkg;

  // Q0.16 coefficient and Q1.16 gain formats
  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned GAIN_BITS = 17;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

  // One multiplier bit per step, over the full 17-bit unsigned factor
  localparam int unsigned MUL_STEPS = GAIN_BITS;
  localparam int unsigned CNT_BITS = $clog2(MUL_STEPS);

  // Register map, index = paddr[4:2]
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_FLOOR     = 3'd2;
  localparam logic [2:0] REG_ATTACK    = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;

  localparam logic [COEF_BITS-1:0] ATTACK_RESET  = 16'd64000;
  localparam logic [COEF_BITS-1:0] RELEASE_RESET = 16'd65000;

endpackage

`default_nettype wire

// ===== design/ngsg_serial_mul.sv =====
`default_nettype none

// Shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
// p_o holds the product shifted right by 16 (floor) once done_o pulses,
// and keeps it until the next start.
module ngsg_serial_mul #(
  parameter int unsigned AW = 18
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [AW-1:0]             a_i,
  input  wire logic [ngsg_pkg::GAIN_BITS-1:0]   b_i,
  output logic                                  done_o,
  output logic signed [AW+1:0]                  p_o
);
  import ngsg_pkg::*;

  logic signed [AW-1:0]  a_q;
  logic [GAIN_BITS-1:0]  b_q;
  logic signed [AW:0]    hi_q;
  logic [GAIN_BITS-1:0]  lo_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic signed [AW+1:0]  sum;

  // Add the partial product into the upper half, then shift one place right
  assign sum = (AW+2)'(hi_q) + (b_q[0] ? (AW+2)'(a_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      b_q  <= {1'b0, b_q[GAIN_BITS-1:1]};
      hi_q <= sum[AW+1:1];
      lo_q <= {sum[0], lo_q[GAIN_BITS-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = {hi_q, lo_q[GAIN_BITS-1]};

endmodule

`default_nettype wire

// ===== design/noise_gate_smoothed_gain_unit.sv =====
`default_nettype none

// Noise gate with peak envelope follower and smoothed gain.
// Input channel (in_valid_i / in_ready_o) carries one signed sample and a
// block_end flag per transaction; the output channel (out_valid_o /
// out_ready_i) returns exactly one gated sample and the copied flag.
// Configuration goes through the APB port: enable, threshold_level,
// floor_gain, attack_coef and release_coef at byte addresses 0,4,8,12,16.
// Write registers only while the block is idle.
// Processing runs three passes through one bit-serial multiplier
// (envelope smoothing, gain smoothing, sample times gain), each of 17
// shift-add steps, the first two with setup and update states around them;
// that multiplier sets the rate. A new sample is accepted only once the
// previous one has left the final state. With enable low, an accepted sample
// goes through the final state into the output register without a multiply,
// and the envelope and gain hold.
// The result sits in an output register: the next sample may be accepted
// while it waits for out_ready_i. If the receiver stalls longer, the
// finished sample waits in the final state and input is held off.
// Reset: envelope 0, gain unity, registers at their reset values, both
// channels empty.
module noise_gate_smoothed_gain_unit #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input  wire logic                              block_end_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]          sample_out_o,
  output logic                                   block_end_out_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ngsg_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [ngsg_pkg::DATA_BITS-1:0]    pwdata,
  output logic [ngsg_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready
);
  import ngsg_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  // operand width: envelope difference needs SB+1, gain difference 18
  localparam int unsigned AW = (SB + 1 > GAIN_BITS + 1) ? SB + 1 : GAIN_BITS + 1;
  // compare width for envelope against the 16-bit threshold
  localparam int unsigned CW = (SB > COEF_BITS) ? SB : COEF_BITS;
  localparam logic [SB-1:0] ENV_MAX = {1'b1, {(SB-1){1'b0}}};

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ENV_SET  = 4'd1;
  localparam logic [3:0] ST_ENV_MUL  = 4'd2;
  localparam logic [3:0] ST_ENV_UPD  = 4'd3;
  localparam logic [3:0] ST_GAIN_SET = 4'd4;
  localparam logic [3:0] ST_GAIN_MUL = 4'd5;
  localparam logic [3:0] ST_GAIN_UPD = 4'd6;
  localparam logic [3:0] ST_OUT_MUL  = 4'd7;
  localparam logic [3:0] ST_FIN      = 4'd8;

  // configuration registers
  logic                  enable_q;
  logic [COEF_BITS-1:0]  thr_q;
  logic [GAIN_BITS-1:0]  floor_q;
  logic [COEF_BITS-1:0]  attack_q;
  logic [COEF_BITS-1:0]  release_q;

  // state and working registers
  logic [3:0]            state_q, state_d;
  logic [SB-1:0]         env_q;
  logic [GAIN_BITS-1:0]  gain_q;
  logic signed [SB-1:0]  sample_q;
  logic [SB-1:0]         mag_q;
  logic                  blk_q;
  logic                  byp_q;
  logic                  out_valid_q;
  logic signed [SB-1:0]  sample_out_q;
  logic                  block_end_out_q;

  logic                  in_fire;
  logic                  cfg_wr;
  logic                  out_load;
  logic [SB-1:0]         mag_in;

  logic                  mul_start;
  logic signed [AW-1:0]  mul_a;
  logic [GAIN_BITS-1:0]  mul_b;
  logic                  mul_done;
  logic signed [AW+1:0]  mul_p;

  logic                  env_rise;
  logic [COEF_BITS-1:0]  env_coef;
  logic [GAIN_BITS-1:0]  floor_sat;
  logic [GAIN_BITS-1:0]  target;
  logic                  gain_rise;
  logic [COEF_BITS-1:0]  gain_coef;
  logic [SB-1:0]         env_new;
  logic [GAIN_BITS-1:0]  gain_new;
  logic signed [SB-1:0]  result;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      thr_q     <= '0;
      floor_q   <= '0;
      attack_q  <= ATTACK_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ENABLE:    enable_q  <= pwdata[0];
        REG_THRESHOLD: thr_q     <= pwdata[COEF_BITS-1:0];
        REG_FLOOR:     floor_q   <= pwdata[GAIN_BITS-1:0];
        REG_ATTACK:    attack_q  <= pwdata[COEF_BITS-1:0];
        REG_RELEASE:   release_q <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ENABLE:    prdata = DATA_BITS'(enable_q);
      REG_THRESHOLD: prdata = DATA_BITS'(thr_q);
      REG_FLOOR:     prdata = DATA_BITS'(floor_q);
      REG_ATTACK:    prdata = DATA_BITS'(attack_q);
      REG_RELEASE:   prdata = DATA_BITS'(release_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- datapath
  // Magnitude; the most negative sample maps to 2^(SB-1), which fits unsigned
  assign mag_in = sample_in_i[SB-1] ? (~sample_in_i + 1'b1) : sample_in_i;

  // Envelope pass: env + floor((65536 - c) * (mag - env) / 65536)
  assign env_rise = (mag_q > env_q);
  assign env_coef = env_rise ? attack_q : release_q;

  // Gain pass: gain + floor((65536 - c) * (target - gain) / 65536)
  assign floor_sat = (floor_q > GAIN_ONE) ? GAIN_ONE : floor_q;
  assign target    = (CW'(env_q) < CW'(thr_q)) ? floor_sat : GAIN_ONE;
  assign gain_rise = (target > gain_q);
  assign gain_coef = gain_rise ? attack_q : release_q;

  assign env_new  = env_q + mul_p[SB-1:0];
  assign gain_new = gain_q + mul_p[GAIN_BITS-1:0];
  assign result   = byp_q ? sample_q : mul_p[SB-1:0];

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_ENV_SET: begin
        mul_start = 1'b1;
        mul_a     = AW'($signed({1'b0, mag_q}) - $signed({1'b0, env_q}));
        mul_b     = GAIN_ONE - GAIN_BITS'(env_coef);
      end
      ST_GAIN_SET: begin
        mul_start = 1'b1;
        mul_a     = AW'($signed({1'b0, target}) - $signed({1'b0, gain_q}));
        mul_b     = GAIN_ONE - GAIN_BITS'(gain_coef);
      end
      ST_GAIN_UPD: begin
        // final pass: sample times the freshly updated gain
        mul_start = 1'b1;
        mul_a     = AW'(sample_q);
        mul_b     = gain_new;
      end
      default: ;
    endcase
  end

  ngsg_serial_mul #(
    .AW(AW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // ---------------------------------------------------------- sequencer
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = enable_q ? ST_ENV_SET : ST_FIN;
      ST_ENV_SET:  state_d = ST_ENV_MUL;
      ST_ENV_MUL:  if (mul_done) state_d = ST_ENV_UPD;
      ST_ENV_UPD:  state_d = ST_GAIN_SET;
      ST_GAIN_SET: state_d = ST_GAIN_MUL;
      ST_GAIN_MUL: if (mul_done) state_d = ST_GAIN_UPD;
      ST_GAIN_UPD: state_d = ST_OUT_MUL;
      ST_OUT_MUL:  if (mul_done) state_d = ST_FIN;
      ST_FIN:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      env_q       <= '0;
      gain_q      <= GAIN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // advance the smoothed state only at the end of its pass
      if (state_q == ST_ENV_UPD) begin
        env_q <= env_new;
      end
      if (state_q == ST_GAIN_UPD) begin
        gain_q <= gain_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted transaction for the whole computation
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_in_i;
      mag_q    <= mag_in;
      blk_q    <= block_end_i;
      byp_q    <= !enable_q;
    end
    if (out_load) begin
      sample_out_q    <= result;
      block_end_out_q <= blk_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = sample_out_q;
  assign block_end_out_o = block_end_out_q;

  // ---------------------------------------------------------- checks
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= GAIN_ONE)
    else $error("smoothed gain above unity");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ENV_MAX)
    else $error("envelope above full-scale magnitude");

  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_ENV_MUL || state_q == ST_GAIN_MUL ||
                  state_q == ST_OUT_MUL))
    else $error("multiplier finished outside a multiply pass");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !enable_q) |=> (state_q == ST_FIN && $stable(gain_q) &&
                                $stable(env_q)))
    else $error("bypass transaction touched the gate state");

endmodule

`default_nettype wire
